[rtl/core/asd_pkg.sv]
`default_nettype none
package asd_pkg;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       payload_end;
  } in_req_t;

  typedef struct packed {
    logic       detected;
    logic [2:0] signature_kind;
    logic [7:0] subtype_byte;
    logic       led_phase;
  } out_req_t;

  typedef logic [2:0] kind_t;

  // Window of previous bytes plus the current one
  localparam int unsigned WIN_DEPTH = 13;
  localparam int unsigned SEQ_LEN   = WIN_DEPTH + 1;
  localparam int unsigned SEQ_BITS  = SEQ_LEN * 8;

  typedef logic [SEQ_BITS-1:0] seq_t;

  localparam kind_t KIND_SIG0 = 3'd0;
  localparam kind_t KIND_SIG1 = 3'd1;
  localparam kind_t KIND_SIG2 = 3'd2;
  localparam kind_t KIND_SIG3 = 3'd3;
  localparam kind_t KIND_SIG4 = 3'd4;

  localparam logic [7:0] TYPE_PROXIMITY_PAIR = 8'h07;
  localparam logic [7:0] TYPE_NEARBY_ACTION  = 8'h0F;

  // Patterns right-aligned: the last signature byte lines up with the current byte
  localparam int unsigned SIG0_LEN = 8;
  localparam seq_t SIG0_PAT  = 112'h0303_2CFE_0616_2CFE;
  localparam seq_t SIG0_MASK = 112'hFFFF_FFFF_FFFF_FFFF;

  // Signature 1 spans four bytes; the current byte is the type byte, checked apart
  localparam int unsigned SIG1_LEN = 4;
  localparam seq_t SIG1_PAT  = 112'hFF4C_0000;
  localparam seq_t SIG1_MASK = 112'hFFFF_FF00;

  localparam int unsigned SIG2_LEN = 14;
  localparam seq_t SIG2_PAT  = 112'h1BFF_7500_4209_8102_1415_0321_0109;
  localparam seq_t SIG2_MASK = 112'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF;

  localparam int unsigned SIG3_LEN = 11;
  localparam seq_t SIG3_PAT  = 112'hFF_FF00_6DB6_43CE_97FE_427C;
  localparam seq_t SIG3_MASK = 112'hFF_FFFF_FFFF_FFFF_FFFF_FFFF;

  localparam int unsigned SIG4_LEN = 6;
  localparam seq_t SIG4_PAT  = 112'hFF06_0003_0080;
  localparam seq_t SIG4_MASK = 112'hFFFF_FFFF_FFFF;

endpackage
`default_nettype wire

[rtl/core/adv_signature_detector.sv]
`default_nettype none
// Channel  Dir  Payload             Handshake
// in_      in   in_req_t            in_valid / in_stall
// out_     out  out_req_t           out_valid / out_stall
//
// One byte per cycle while no last byte is stalled; the match for a byte is resolved in the cycle it is taken.
// A result is registered from the byte marked last and sits in the output
// register until taken; non-last bytes are still taken while it waits.
// A last byte is stalled only while a previous result is held by out_stall.
// Synchronous active-low reset clears position, match state and LED phase.
module adv_signature_detector #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 62
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire asd_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output asd_pkg::out_req_t      out_data
);
  import asd_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAYLOAD_BYTES + 1);

  logic [WIN_DEPTH-1:0][7:0] win_r, win_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic                      seen_r, seen_nxt;
  logic [PW-1:0]             best_start_r, best_start_nxt;
  kind_t                     best_kind_r, best_kind_nxt;
  logic [7:0]                best_sub_r, best_sub_nxt;
  logic                      led_r, led_nxt;
  logic                      out_valid_r;
  out_req_t                  out_data_r, out_data_nxt;

  logic       in_acc;
  logic       scan_en;
  seq_t       seq;
  logic       hit0, hit1, hit2, hit3, hit4, hit_any;
  logic [PW-1:0] cand_start;
  kind_t      cand_kind;
  logic       take;

  assign in_stall  = out_valid_r && out_stall && in_data.payload_end;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign scan_en = pos_r < PW'(MAX_PAYLOAD_BYTES);
  assign seq     = {win_r, in_data.adv_byte};

  always_comb begin
    hit0 = (((seq ^ SIG0_PAT) & SIG0_MASK) == '0) && (pos_r >= PW'(SIG0_LEN - 1));
    hit1 = (((seq ^ SIG1_PAT) & SIG1_MASK) == '0) && (pos_r >= PW'(SIG1_LEN - 1))
           && (in_data.adv_byte == TYPE_PROXIMITY_PAIR
               || in_data.adv_byte == TYPE_NEARBY_ACTION);
    hit2 = (((seq ^ SIG2_PAT) & SIG2_MASK) == '0) && (pos_r >= PW'(SIG2_LEN - 1));
    hit3 = (((seq ^ SIG3_PAT) & SIG3_MASK) == '0) && (pos_r >= PW'(SIG3_LEN - 1));
    hit4 = (((seq ^ SIG4_PAT) & SIG4_MASK) == '0) && (pos_r >= PW'(SIG4_LEN - 1));
    hit_any = hit0 || hit1 || hit2 || hit3 || hit4;

    // shortest signature ending here has the greatest start
    if (hit1) begin
      cand_start = pos_r - PW'(SIG1_LEN - 1);
      cand_kind  = KIND_SIG1;
    end else if (hit4) begin
      cand_start = pos_r - PW'(SIG4_LEN - 1);
      cand_kind  = KIND_SIG4;
    end else if (hit0) begin
      cand_start = pos_r - PW'(SIG0_LEN - 1);
      cand_kind  = KIND_SIG0;
    end else if (hit3) begin
      cand_start = pos_r - PW'(SIG3_LEN - 1);
      cand_kind  = KIND_SIG3;
    end else begin
      cand_start = pos_r - PW'(SIG2_LEN - 1);
      cand_kind  = KIND_SIG2;
    end

    take = scan_en && hit_any &&
           (!seen_r || cand_start > best_start_r ||
            (cand_start == best_start_r && cand_kind > best_kind_r));

    win_nxt        = win_r;
    pos_nxt        = pos_r;
    seen_nxt       = seen_r;
    best_start_nxt = best_start_r;
    best_kind_nxt  = best_kind_r;
    best_sub_nxt   = best_sub_r;
    if (scan_en) begin
      win_nxt = {win_r[WIN_DEPTH-2:0], in_data.adv_byte};
      pos_nxt = pos_r + PW'(1);
    end
    if (take) begin
      seen_nxt       = 1'b1;
      best_start_nxt = cand_start;
      best_kind_nxt  = cand_kind;
      best_sub_nxt   = in_data.adv_byte;
    end

    led_nxt = led_r ^ seen_nxt;

    out_data_nxt.detected       = seen_nxt;
    out_data_nxt.signature_kind = seen_nxt ? best_kind_nxt : KIND_SIG0;
    out_data_nxt.subtype_byte   = (seen_nxt && best_kind_nxt == KIND_SIG1) ? best_sub_nxt
                                                                           : 8'h00;
    out_data_nxt.led_phase      = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seen_r      <= 1'b0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new report replaces the one taken in the same cycle
      if (in_acc && in_data.payload_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_data.payload_end) begin
          // report, then start the next payload clean
          led_r       <= led_nxt;
          pos_r       <= '0;
          seen_r      <= 1'b0;
        end else begin
          pos_r  <= pos_nxt;
          seen_r <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r        <= win_nxt;
      best_start_r <= best_start_nxt;
      best_kind_r  <= best_kind_nxt;
      best_sub_r   <= best_sub_nxt;
      if (in_data.payload_end) begin
        out_data_r <= out_data_nxt;
      end
    end
  end

endmodule
`default_nettype wire
